[rtl/core/tps_pkg.sv]
`timescale 1ns / 1ps

package tps_pkg;

  // Number formats and field widths.
  localparam int COORD_FRAC_BITS = 10;
  localparam int COORD_W         = 21;
  localparam int VERT_W          = 3 * COORD_W;
  localparam int TEX_W           = 16;
  localparam int TEXP_W          = 2 * TEX_W;
  localparam int OFFS_W          = 10;
  localparam int AXIS_W          = 2;
  localparam int MODE_W          = 2;
  localparam int N_VERT          = 3;
  localparam int N_CAND          = 3;
  localparam int N_CUT           = 2;
  localparam int N_COMP          = 5;
  localparam int N_LANE          = N_CUT * N_COMP;

  // Discard mode bits.
  localparam int MODE_DROP_LO_BIT = 0;
  localparam int MODE_DROP_HI_BIT = 1;

  // Plane in position format, and the arithmetic widths of a cut.
  localparam int PLANE_W = OFFS_W + COORD_FRAC_BITS + 1;
  localparam int NUM_W   = ((PLANE_W > COORD_W) ? PLANE_W : COORD_W) + 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = NUM_W + DIFF_W;

  // Divider: quotient bits, bits resolved per stage, stage count.
  localparam int Q_W        = 24;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEP;

  // Lane latency: input, multiply, magnitude, divider stages, final add.
  localparam int LANE_LAT = DIV_STAGES + 4;

  // Cycles between accepted items; one result channel carries up to three triangles.
  localparam int ACCEPT_GAP = 3;
  localparam int GAP_W      = $clog2(ACCEPT_GAP);

  typedef logic [1:0] vidx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Source of one vertex of a sub-triangle.
  typedef enum logic [2:0] {
    SRC_V0,
    SRC_V1,
    SRC_V2,
    SRC_X0,
    SRC_X1
  } src_t;

  typedef struct packed {
    logic [N_VERT-1:0][VERT_W-1:0] v;
    logic [N_VERT-1:0][TEXP_W-1:0] t;
  } item_t;

  typedef struct packed {
    axis_t                             axis;
    logic signed [PLANE_W-1:0]         plane;
    vidx_t [N_CUT-1:0]                 cut_a;
    vidx_t [N_CUT-1:0]                 cut_b;
    src_t [N_CAND-1:0][N_VERT-1:0]     sel;
    logic [N_CAND-1:0]                 lo;
    logic [N_CAND-1:0]                 keep;
  } ctrl_t;

  typedef struct packed {
    logic [N_VERT-1:0][VERT_W-1:0] v;
    logic [N_VERT-1:0][TEXP_W-1:0] t;
    logic                          lo;
  } tri_t;

  // Next vertex index modulo three.
  function automatic vidx_t next3(input vidx_t i);
    vidx_t r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Source code of an input vertex.
  function automatic src_t vsrc(input vidx_t i);
    src_t r;
    case (i)
      2'd0:    r = SRC_V0;
      2'd1:    r = SRC_V1;
      default: r = SRC_V2;
    endcase
    return r;
  endfunction

  // Coordinate of a packed vertex along an axis.
  function automatic logic signed [COORD_W-1:0] coord_of(input logic [VERT_W-1:0] v,
                                                         input axis_t ax);
    logic signed [COORD_W-1:0] r;
    case (ax)
      AXIS_X:  r = v[0*COORD_W +: COORD_W];
      AXIS_Y:  r = v[1*COORD_W +: COORD_W];
      default: r = v[2*COORD_W +: COORD_W];
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tps_classify.sv]
`timescale 1ns / 1ps

module tps_classify (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tps_pkg::item_t              in_item,
  input  logic [tps_pkg::AXIS_W-1:0]  in_axis,
  input  logic [tps_pkg::OFFS_W-1:0]  in_offset,
  input  logic [tps_pkg::MODE_W-1:0]  in_mode,
  output logic                        out_valid_r,
  output tps_pkg::item_t              out_item_r,
  output tps_pkg::ctrl_t              out_ctrl_r
);

  tps_pkg::ctrl_t                         ctrl_nxt;
  tps_pkg::axis_t                         axis;
  logic signed [tps_pkg::PLANE_W-1:0]     plane;
  logic signed [tps_pkg::NUM_W-1:0]       plane_x;
  logic signed [tps_pkg::NUM_W-1:0]       coord_x [tps_pkg::N_VERT];
  logic [tps_pkg::N_VERT-1:0]             lo;
  logic [tps_pkg::N_VERT-1:0]             pl;
  logic [1:0]                             lo_sum;
  logic [1:0]                             pl_sum;
  logic [1:0]                             nl;
  logic [tps_pkg::N_CAND-1:0]             en;
  tps_pkg::vidx_t                         pi, n0, n1, iso;
  logic                                   iso_lo;

  // Axis three is treated as z; the plane sits on an integer coordinate.
  always_comb begin
    if (in_axis == tps_pkg::AXIS_X) begin
      axis = tps_pkg::AXIS_X;
    end else if (in_axis == tps_pkg::AXIS_Y) begin
      axis = tps_pkg::AXIS_Y;
    end else begin
      axis = tps_pkg::AXIS_Z;
    end
    plane   = $signed({1'b0, in_offset, {tps_pkg::COORD_FRAC_BITS{1'b0}}});
    plane_x = tps_pkg::NUM_W'(plane);
  end

  // Each vertex is below the plane, on it, or above it.
  always_comb begin
    for (int i = 0; i < tps_pkg::N_VERT; i++) begin
      coord_x[i] = tps_pkg::NUM_W'(tps_pkg::coord_of(in_item.v[i], axis));
      lo[i]      = coord_x[i] < plane_x;
      pl[i]      = coord_x[i] == plane_x;
    end
    lo_sum = {1'b0, lo[0]} + {1'b0, lo[1]} + {1'b0, lo[2]};
    pl_sum = {1'b0, pl[0]} + {1'b0, pl[1]} + {1'b0, pl[2]};
  end

  // Case decision: which cuts, which sub-triangles, which side each goes to.
  always_comb begin
    ctrl_nxt       = '0;
    ctrl_nxt.axis  = axis;
    ctrl_nxt.plane = plane;
    for (int k = 0; k < tps_pkg::N_CAND; k++) begin
      ctrl_nxt.sel[k][0] = tps_pkg::SRC_V0;
      ctrl_nxt.sel[k][1] = tps_pkg::SRC_V1;
      ctrl_nxt.sel[k][2] = tps_pkg::SRC_V2;
    end
    en     = 3'b001;
    pi     = pl[0] ? 2'd0 : (pl[1] ? 2'd1 : 2'd2);
    n0     = tps_pkg::next3(pi);
    n1     = tps_pkg::next3(n0);
    nl     = {1'b0, lo[n0]} + {1'b0, lo[n1]};
    iso_lo = lo_sum == 2'd1;
    if (iso_lo) begin
      iso = lo[0] ? 2'd0 : (lo[1] ? 2'd1 : 2'd2);
    end else begin
      iso = !lo[0] ? 2'd0 : (!lo[1] ? 2'd1 : 2'd2);
    end

    if (lo_sum == 2'd0 || lo_sum == 2'd3) begin
      ctrl_nxt.lo[0] = lo_sum == 2'd3;
    end else if (pl_sum == 2'd3) begin
      ctrl_nxt.lo[0] = 1'b0;
    end else if (pl_sum == 2'd2) begin
      // Two on the plane: the free vertex decides the side.
      ctrl_nxt.lo[0] = !pl[0] ? lo[0] : (!pl[1] ? lo[1] : lo[2]);
    end else if (pl_sum == 2'd1) begin
      if (nl != 2'd1) begin
        ctrl_nxt.lo[0] = nl == 2'd2;
      end else begin
        // One cut on the edge opposite the planar vertex.
        ctrl_nxt.cut_a[0]  = n0;
        ctrl_nxt.cut_b[0]  = n1;
        ctrl_nxt.sel[0][0] = tps_pkg::vsrc(pi);
        ctrl_nxt.sel[0][1] = tps_pkg::vsrc(n0);
        ctrl_nxt.sel[0][2] = tps_pkg::SRC_X0;
        ctrl_nxt.lo[0]     = lo[n0];
        ctrl_nxt.sel[1][0] = tps_pkg::vsrc(pi);
        ctrl_nxt.sel[1][1] = tps_pkg::SRC_X0;
        ctrl_nxt.sel[1][2] = tps_pkg::vsrc(n1);
        ctrl_nxt.lo[1]     = !lo[n0];
        en                 = 3'b011;
      end
    end else begin
      // Regular case: isolated triangle and the two halves of the quad.
      ctrl_nxt.cut_a[0]  = iso;
      ctrl_nxt.cut_b[0]  = tps_pkg::next3(iso);
      ctrl_nxt.cut_a[1]  = iso;
      ctrl_nxt.cut_b[1]  = tps_pkg::next3(tps_pkg::next3(iso));
      ctrl_nxt.sel[0][0] = tps_pkg::vsrc(iso);
      ctrl_nxt.sel[0][1] = tps_pkg::SRC_X0;
      ctrl_nxt.sel[0][2] = tps_pkg::SRC_X1;
      ctrl_nxt.lo[0]     = iso_lo;
      ctrl_nxt.sel[1][0] = tps_pkg::SRC_X0;
      ctrl_nxt.sel[1][1] = tps_pkg::vsrc(tps_pkg::next3(iso));
      ctrl_nxt.sel[1][2] = tps_pkg::vsrc(tps_pkg::next3(tps_pkg::next3(iso)));
      ctrl_nxt.lo[1]     = !iso_lo;
      ctrl_nxt.sel[2][0] = tps_pkg::SRC_X0;
      ctrl_nxt.sel[2][1] = tps_pkg::SRC_X1;
      ctrl_nxt.sel[2][2] = tps_pkg::vsrc(tps_pkg::next3(tps_pkg::next3(iso)));
      ctrl_nxt.lo[2]     = !iso_lo;
      en                 = 3'b111;
    end

    // The discard mode removes whole sides.
    for (int k = 0; k < tps_pkg::N_CAND; k++) begin
      ctrl_nxt.keep[k] = en[k] && !(ctrl_nxt.lo[k] ? in_mode[tps_pkg::MODE_DROP_LO_BIT]
                                                   : in_mode[tps_pkg::MODE_DROP_HI_BIT]);
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= in_item;
    out_ctrl_r <= ctrl_nxt;
  end

endmodule

[rtl/core/tps_lane.sv]
`timescale 1ns / 1ps

module tps_lane (
  input  logic                               clk,
  input  logic signed [tps_pkg::DIFF_W-1:0]  in_base,
  input  logic signed [tps_pkg::DIFF_W-1:0]  in_diff,
  input  logic signed [tps_pkg::NUM_W-1:0]   in_num,
  input  logic [tps_pkg::DIFF_W-1:0]         in_den,
  output logic signed [tps_pkg::DIFF_W-1:0]  out_res_r
);

  localparam int DW = tps_pkg::DIFF_W;
  localparam int QW = tps_pkg::Q_W;
  localparam int NS = tps_pkg::DIV_STAGES;

  logic signed [DW-1:0]              base1_r, diff1_r;
  logic signed [tps_pkg::NUM_W-1:0]  num1_r;
  logic [DW-1:0]                     den1_r;
  logic signed [tps_pkg::PROD_W-1:0] prod2_r;
  logic signed [DW-1:0]              base2_r;
  logic [DW-1:0]                     den2_r;
  logic [tps_pkg::PROD_W-1:0]        mag3_r;
  logic                              neg3_r;
  logic signed [DW-1:0]              base3_r;
  logic [DW-1:0]                     den3_r;

  logic [DW-1:0]        rem_in  [NS];
  logic [QW-1:0]        low_in  [NS];
  logic [DW-1:0]        den_in  [NS];
  logic                 neg_in  [NS];
  logic signed [DW-1:0] base_in [NS];
  logic [DW-1:0]        rem_nxt [NS];
  logic [QW-1:0]        low_nxt [NS];
  logic [DW-1:0]        rem_r   [NS];
  logic [QW-1:0]        low_r   [NS];
  logic [DW-1:0]        den_r   [NS];
  logic                 neg_r   [NS];
  logic signed [DW-1:0] base_r  [NS];

  logic signed [DW-1:0] quot;

  // Input, product and magnitude stages.
  always_ff @(posedge clk) begin
    base1_r <= in_base;
    diff1_r <= in_diff;
    num1_r  <= in_num;
    den1_r  <= in_den;
    prod2_r <= tps_pkg::PROD_W'(diff1_r) * tps_pkg::PROD_W'(num1_r);
    base2_r <= base1_r;
    den2_r  <= den1_r;
    neg3_r  <= prod2_r[tps_pkg::PROD_W-1];
    mag3_r  <= prod2_r[tps_pkg::PROD_W-1] ? tps_pkg::PROD_W'(-prod2_r)
                                          : tps_pkg::PROD_W'(prod2_r);
    base3_r <= base2_r;
    den3_r  <= den2_r;
  end

  // Restoring division, four quotient bits per stage. The quotient bits
  // shift into the low end of the dividend register.
  always_comb begin
    logic [DW:0] r;
    rem_in[0]  = DW'(mag3_r >> QW);
    low_in[0]  = mag3_r[QW-1:0];
    den_in[0]  = den3_r;
    neg_in[0]  = neg3_r;
    base_in[0] = base3_r;
    for (int s = 1; s < NS; s++) begin
      rem_in[s]  = rem_r[s-1];
      low_in[s]  = low_r[s-1];
      den_in[s]  = den_r[s-1];
      neg_in[s]  = neg_r[s-1];
      base_in[s] = base_r[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      rem_nxt[s] = rem_in[s];
      low_nxt[s] = low_in[s];
      for (int b = 0; b < tps_pkg::DIV_STEP; b++) begin
        r          = {rem_nxt[s], low_nxt[s][QW-1]};
        low_nxt[s] = {low_nxt[s][QW-2:0], 1'b0};
        if (r >= {1'b0, den_in[s]}) begin
          r             = r - {1'b0, den_in[s]};
          low_nxt[s][0] = 1'b1;
        end
        rem_nxt[s] = r[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      rem_r[s]  <= rem_nxt[s];
      low_r[s]  <= low_nxt[s];
      den_r[s]  <= den_in[s];
      neg_r[s]  <= neg_in[s];
      base_r[s] <= base_in[s];
    end
  end

  // Signed quotient added to the start point of the edge.
  assign quot = $signed(DW'(low_r[NS-1]));

  always_ff @(posedge clk) begin
    out_res_r <= base_r[NS-1] + (neg_r[NS-1] ? -quot : quot);
  end

endmodule

[rtl/core/tps_emit.sv]
`timescale 1ns / 1ps

module tps_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  tps_pkg::tri_t [tps_pkg::N_CAND-1:0]  in_cand,
  input  logic [tps_pkg::N_CAND-1:0]           in_keep,
  output logic                                 out_valid,
  output logic [tps_pkg::VERT_W-1:0]           out_vertex_a,
  output logic [tps_pkg::VERT_W-1:0]           out_vertex_b,
  output logic [tps_pkg::VERT_W-1:0]           out_vertex_c,
  output logic [tps_pkg::TEXP_W-1:0]           out_tex_a,
  output logic [tps_pkg::TEXP_W-1:0]           out_tex_b,
  output logic [tps_pkg::TEXP_W-1:0]           out_tex_c,
  output logic                                 out_goes_low,
  output logic                                 out_last_of_run
);

  tps_pkg::tri_t slot_nxt [tps_pkg::N_CAND];
  tps_pkg::tri_t slot_r   [tps_pkg::N_CAND];
  tps_pkg::tri_t cur;
  logic [1:0]    cnt_nxt;
  logic [1:0]    cnt_r;
  logic [1:0]    idx_r;
  logic          act_r;
  logic          load;

  // Kept sub-triangles are packed to the front, in order.
  always_comb begin
    cnt_nxt     = {1'b0, in_keep[0]} + {1'b0, in_keep[1]} + {1'b0, in_keep[2]};
    slot_nxt[0] = in_keep[0] ? in_cand[0] : (in_keep[1] ? in_cand[1] : in_cand[2]);
    slot_nxt[1] = (in_keep[0] && in_keep[1]) ? in_cand[1] : in_cand[2];
    slot_nxt[2] = in_cand[2];
    load        = in_valid && (cnt_nxt != 2'd0);
  end

  // Run control: one beat per cycle until the count is used up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= 2'd0;
      cnt_r <= 2'd0;
    end else if (load) begin
      act_r <= 1'b1;
      idx_r <= 2'd0;
      cnt_r <= cnt_nxt;
    end else if (act_r) begin
      if (idx_r == cnt_r - 2'd1) begin
        act_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < tps_pkg::N_CAND; k++) begin
        slot_r[k] <= slot_nxt[k];
      end
    end
  end

  // Output beat.
  always_comb begin
    cur             = slot_r[idx_r];
    out_valid       = act_r;
    out_vertex_a    = cur.v[0];
    out_vertex_b    = cur.v[1];
    out_vertex_c    = cur.v[2];
    out_tex_a       = cur.t[0];
    out_tex_b       = cur.t[1];
    out_tex_c       = cur.t[2];
    out_goes_low    = cur.lo;
    out_last_of_run = act_r && (idx_r == cnt_r - 2'd1);
  end

endmodule

[rtl/core/triangle_axis_plane_split.sv]
`timescale 1ns / 1ps

// Channel   | ports                                   | handshake
// ----------+-----------------------------------------+--------------------------
// input     | in_vertex_a..c, in_tex_a..c, in_split_  | start high, busy low
//           | axis, in_plane_offset, in_discard_mode  |
// result    | out_vertex_a..c, out_tex_a..c,          | out_valid high per beat
//           | out_goes_low, out_last_of_run           |
//
// A triangle is accepted while busy is low, even with others in flight; busy is
// raised after an accept, as the single result channel carries
// up to 3 beats per item. An accepted item passes the input register,
// classify, the cut lanes (input, multiply, magnitude, 6 divider stages, add),
// and the emit register. A triangle with every side discarded gives no beat.
// Reset (synchronous, rst_n low) clears all valid bits and the busy count.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
module triangle_axis_plane_split (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tps_pkg::VERT_W-1:0]         in_vertex_a,
  input  logic [tps_pkg::VERT_W-1:0]         in_vertex_b,
  input  logic [tps_pkg::VERT_W-1:0]         in_vertex_c,
  input  logic [tps_pkg::TEXP_W-1:0]         in_tex_a,
  input  logic [tps_pkg::TEXP_W-1:0]         in_tex_b,
  input  logic [tps_pkg::TEXP_W-1:0]         in_tex_c,
  input  logic [tps_pkg::AXIS_W-1:0]         in_split_axis,
  input  logic [tps_pkg::OFFS_W-1:0]         in_plane_offset,
  input  logic [tps_pkg::MODE_W-1:0]         in_discard_mode,
  output logic                               out_valid,
  output logic [tps_pkg::VERT_W-1:0]         out_vertex_a,
  output logic [tps_pkg::VERT_W-1:0]         out_vertex_b,
  output logic [tps_pkg::VERT_W-1:0]         out_vertex_c,
  output logic [tps_pkg::TEXP_W-1:0]         out_tex_a,
  output logic [tps_pkg::TEXP_W-1:0]         out_tex_b,
  output logic [tps_pkg::TEXP_W-1:0]         out_tex_c,
  output logic                               out_goes_low,
  output logic                               out_last_of_run
);

  localparam int DW = tps_pkg::DIFF_W;
  localparam int CW = tps_pkg::COORD_W;
  localparam int TW = tps_pkg::TEX_W;
  localparam int LL = tps_pkg::LANE_LAT;

  logic                               accept;
  logic [tps_pkg::GAP_W-1:0]          gap_r;
  logic                               s1_valid_r;
  tps_pkg::item_t                     s1_item_r;
  logic [tps_pkg::AXIS_W-1:0]         s1_axis_r;
  logic [tps_pkg::OFFS_W-1:0]         s1_offset_r;
  logic [tps_pkg::MODE_W-1:0]         s1_mode_r;
  logic                               s2_valid_r;
  tps_pkg::item_t                     s2_item_r;
  tps_pkg::ctrl_t                     s2_ctrl_r;

  logic signed [DW-1:0]               ln_base [tps_pkg::N_LANE];
  logic signed [DW-1:0]               ln_diff [tps_pkg::N_LANE];
  logic signed [tps_pkg::NUM_W-1:0]   ln_num  [tps_pkg::N_LANE];
  logic [DW-1:0]                      ln_den  [tps_pkg::N_LANE];
  logic signed [DW-1:0]               ln_res  [tps_pkg::N_LANE];

  logic [LL-1:0]                      dl_valid_r;
  tps_pkg::ctrl_t                     dl_ctrl_r [LL];
  tps_pkg::item_t                     dl_item_r [LL];

  logic [tps_pkg::N_CUT-1:0][tps_pkg::VERT_W-1:0] xv;
  logic [tps_pkg::N_CUT-1:0][tps_pkg::TEXP_W-1:0] xt;
  tps_pkg::tri_t [tps_pkg::N_CAND-1:0]            cand;

  // Intake: a new item is taken only while busy is low.
  assign accept = start && !busy;
  assign busy   = gap_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        gap_r <= tps_pkg::GAP_W'(tps_pkg::ACCEPT_GAP - 1);
      end else if (gap_r != '0) begin
        gap_r <= gap_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.v <= {in_vertex_c, in_vertex_b, in_vertex_a};
      s1_item_r.t <= {in_tex_c, in_tex_b, in_tex_a};
      s1_axis_r   <= in_split_axis;
      s1_offset_r <= in_plane_offset;
      s1_mode_r   <= in_discard_mode;
    end
  end

  tps_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s1_valid_r),
    .in_item     (s1_item_r),
    .in_axis     (s1_axis_r),
    .in_offset   (s1_offset_r),
    .in_mode     (s1_mode_r),
    .out_valid_r (s2_valid_r),
    .out_item_r  (s2_item_r),
    .out_ctrl_r  (s2_ctrl_r)
  );

  // Cut setup: edge endpoints, plane distance and axis span, sign-normalized.
  always_comb begin
    logic [tps_pkg::VERT_W-1:0]         va, vb;
    logic [tps_pkg::TEXP_W-1:0]         ta, tb;
    logic signed [tps_pkg::NUM_W-1:0]   nn;
    logic signed [DW-1:0]               dd;
    logic signed [CW-1:0]               ca, cb;
    for (int c = 0; c < tps_pkg::N_CUT; c++) begin
      va = s2_item_r.v[s2_ctrl_r.cut_a[c]];
      vb = s2_item_r.v[s2_ctrl_r.cut_b[c]];
      ta = s2_item_r.t[s2_ctrl_r.cut_a[c]];
      tb = s2_item_r.t[s2_ctrl_r.cut_b[c]];
      ca = tps_pkg::coord_of(va, s2_ctrl_r.axis);
      cb = tps_pkg::coord_of(vb, s2_ctrl_r.axis);
      nn = tps_pkg::NUM_W'(s2_ctrl_r.plane) - tps_pkg::NUM_W'(ca);
      dd = DW'(cb) - DW'(ca);
      if (dd < 0) begin
        dd = -dd;
        nn = -nn;
      end
      for (int k = 0; k < 3; k++) begin
        ca = va[k*CW +: CW];
        cb = vb[k*CW +: CW];
        ln_base[c*tps_pkg::N_COMP + k] = DW'(ca);
        ln_diff[c*tps_pkg::N_COMP + k] = DW'(cb) - DW'(ca);
      end
      for (int k = 0; k < 2; k++) begin
        ln_base[c*tps_pkg::N_COMP + 3 + k] = $signed(DW'(ta[k*TW +: TW]));
        ln_diff[c*tps_pkg::N_COMP + 3 + k] = $signed(DW'(tb[k*TW +: TW]))
                                           - $signed(DW'(ta[k*TW +: TW]));
      end
      for (int k = 0; k < tps_pkg::N_COMP; k++) begin
        ln_num[c*tps_pkg::N_COMP + k] = nn;
        ln_den[c*tps_pkg::N_COMP + k] = DW'(dd);
      end
    end
  end

  // One interpolation lane per component of each cut.
  for (genvar g = 0; g < tps_pkg::N_LANE; g++) begin : g_lane
    tps_lane u_lane (
      .clk       (clk),
      .in_base   (ln_base[g]),
      .in_diff   (ln_diff[g]),
      .in_num    (ln_num[g]),
      .in_den    (ln_den[g]),
      .out_res_r (ln_res[g])
    );
  end

  // Control and source vertices travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_valid_r <= '0;
    end else begin
      dl_valid_r <= {dl_valid_r[LL-2:0], s2_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    dl_ctrl_r[0] <= s2_ctrl_r;
    dl_item_r[0] <= s2_item_r;
    for (int s = 1; s < LL; s++) begin
      dl_ctrl_r[s] <= dl_ctrl_r[s-1];
      dl_item_r[s] <= dl_item_r[s-1];
    end
  end

  // Cut points; the axis component is exactly the plane.
  always_comb begin
    for (int c = 0; c < tps_pkg::N_CUT; c++) begin
      for (int k = 0; k < 3; k++) begin
        if (k == int'(dl_ctrl_r[LL-1].axis)) begin
          xv[c][k*CW +: CW] = CW'(dl_ctrl_r[LL-1].plane);
        end else begin
          xv[c][k*CW +: CW] = ln_res[c*tps_pkg::N_COMP + k][CW-1:0];
        end
      end
      xt[c] = {ln_res[c*tps_pkg::N_COMP + 4][TW-1:0], ln_res[c*tps_pkg::N_COMP + 3][TW-1:0]};
    end
  end

  // Sub-triangle assembly from the selected sources.
  always_comb begin
    for (int k = 0; k < tps_pkg::N_CAND; k++) begin
      cand[k].lo = dl_ctrl_r[LL-1].lo[k];
      for (int j = 0; j < tps_pkg::N_VERT; j++) begin
        case (dl_ctrl_r[LL-1].sel[k][j])
          tps_pkg::SRC_X0: begin
            cand[k].v[j] = xv[0];
            cand[k].t[j] = xt[0];
          end
          tps_pkg::SRC_X1: begin
            cand[k].v[j] = xv[1];
            cand[k].t[j] = xt[1];
          end
          tps_pkg::SRC_V1: begin
            cand[k].v[j] = dl_item_r[LL-1].v[1];
            cand[k].t[j] = dl_item_r[LL-1].t[1];
          end
          tps_pkg::SRC_V2: begin
            cand[k].v[j] = dl_item_r[LL-1].v[2];
            cand[k].t[j] = dl_item_r[LL-1].t[2];
          end
          default: begin
            cand[k].v[j] = dl_item_r[LL-1].v[0];
            cand[k].t[j] = dl_item_r[LL-1].t[0];
          end
        endcase
      end
    end
  end

  tps_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (dl_valid_r[LL-1]),
    .in_cand         (cand),
    .in_keep         (dl_ctrl_r[LL-1].keep),
    .out_valid       (out_valid),
    .out_vertex_a    (out_vertex_a),
    .out_vertex_b    (out_vertex_b),
    .out_vertex_c    (out_vertex_c),
    .out_tex_a       (out_tex_a),
    .out_tex_b       (out_tex_b),
    .out_tex_c       (out_tex_c),
    .out_goes_low    (out_goes_low),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[rtl/core/tps_checker.sv]
`timescale 1ns / 1ps

module tps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [tps_pkg::VERT_W-1:0]    in_vertex_a,
  input logic [tps_pkg::VERT_W-1:0]    in_vertex_b,
  input logic [tps_pkg::VERT_W-1:0]    in_vertex_c,
  input logic [tps_pkg::TEXP_W-1:0]    in_tex_a,
  input logic [tps_pkg::TEXP_W-1:0]    in_tex_b,
  input logic [tps_pkg::TEXP_W-1:0]    in_tex_c,
  input logic [tps_pkg::AXIS_W-1:0]    in_split_axis,
  input logic [tps_pkg::OFFS_W-1:0]    in_plane_offset,
  input logic [tps_pkg::MODE_W-1:0]    in_discard_mode,
  input logic                          out_valid,
  input logic [tps_pkg::VERT_W-1:0]    out_vertex_a,
  input logic [tps_pkg::VERT_W-1:0]    out_vertex_b,
  input logic [tps_pkg::VERT_W-1:0]    out_vertex_c,
  input logic [tps_pkg::TEXP_W-1:0]    out_tex_a,
  input logic [tps_pkg::TEXP_W-1:0]    out_tex_b,
  input logic [tps_pkg::TEXP_W-1:0]    out_tex_c,
  input logic                          out_goes_low,
  input logic                          out_last_of_run
);

  // After an accept the block raises busy and holds it, as the two checks below require.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_busy_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 busy)
    else $error("busy dropped early");

  // A run of beats is contiguous until its last beat.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> out_valid)
    else $error("gap inside a run of beats");

  // The end-of-run mark only appears on a beat.
  a_last_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_run |-> out_valid)
    else $error("last mark without a beat");

endmodule

bind triangle_axis_plane_split tps_checker u_tps_checker (.*);
